// ----- rtl/ufq_pkg.sv -----
// ----------------------------------------------------------------------------
// ufq_pkg
// Types and codes shared by the urgent front queue and its storage cells.
// ----------------------------------------------------------------------------
package ufq_pkg;

  localparam int ID_W   = 16;
  localparam int AGE_W  = 8;
  localparam int SEV_W  = 4;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;

  // Command codes
  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_DEQUEUE = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

  localparam logic [SEV_W-1:0] THRESHOLD_RESET = 4'd9;

  // One stored entry
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [AGE_W-1:0] age;
    logic [SEV_W-1:0] sev;
  } entry_t;

  // Cell operations
  localparam logic [1:0] OP_HOLD       = 2'd0;
  localparam logic [1:0] OP_TAKE_LEFT  = 2'd1;
  localparam logic [1:0] OP_TAKE_RIGHT = 2'd2;
  localparam logic [1:0] OP_LOAD       = 2'd3;

  typedef struct packed {
    logic [1:0] op;
  } cell_ctrl_t;

endpackage

// ----- rtl/ufq_cell.sv -----
// ----------------------------------------------------------------------------
// ufq_cell
// One queue slot: holds an entry, takes it from a neighbour or from the input.
// ----------------------------------------------------------------------------
module ufq_cell (
  input  logic                clk,
  input  ufq_pkg::cell_ctrl_t ctrl,
  input  ufq_pkg::entry_t     left,
  input  ufq_pkg::entry_t     right,
  input  ufq_pkg::entry_t     load,
  output ufq_pkg::entry_t     q
);

  ufq_pkg::entry_t q_next;

  always_comb begin
    case (ctrl.op)
      ufq_pkg::OP_HOLD:       q_next = q;
      ufq_pkg::OP_TAKE_LEFT:  q_next = left;
      ufq_pkg::OP_TAKE_RIGHT: q_next = right;
      ufq_pkg::OP_LOAD:       q_next = load;
      default:                q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

// ----- rtl/urgent_front_queue.sv -----
// ----------------------------------------------------------------------------
// urgent_front_queue
// Bounded double-ended queue with urgent entries pushed at the front.
//
// The queue holds up to QUEUE_DEPTH entries of id, age and severity in a row
// of cells, the front entry always in the first cell. An enqueue whose
// severity is at or above urgent_threshold shifts the row one cell back and
// enters at the front, so urgent entries leave last-in-first-out ahead of the
// rest; any other enqueue is written into the first free cell. A dequeue
// shifts the row one cell forward and reports the entry that left. Each item
// gives one result with a status (done, dequeue on empty, enqueue dropped
// because full), the dequeued entry (zero if none), the front entry after
// the step (zero when empty) and the occupancy, masked to five bits. For
// each item the row of cells moves and the result goes into an output
// register, so a new item is taken every cycle unless that register holds
// a result that is stalled. Write urgent_threshold only while no item is in
// flight; it resets to 9.
// ----------------------------------------------------------------------------
module urgent_front_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_we,
  input  logic [ufq_pkg::SEV_W-1:0]     cfg_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          cmd,
  input  logic [ufq_pkg::ID_W-1:0]      entry_id,
  input  logic [ufq_pkg::AGE_W-1:0]     entry_age,
  input  logic [ufq_pkg::SEV_W-1:0]     entry_severity,
  // output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ufq_pkg::STAT_W-1:0]    status,
  output logic [ufq_pkg::ID_W-1:0]      popped_id,
  output logic [ufq_pkg::AGE_W-1:0]     popped_age,
  output logic [ufq_pkg::SEV_W-1:0]     popped_severity,
  output logic                          head_valid,
  output logic [ufq_pkg::ID_W-1:0]      head_id,
  output logic [ufq_pkg::AGE_W-1:0]     head_age,
  output logic [ufq_pkg::SEV_W-1:0]     head_severity,
  output logic [ufq_pkg::OCC_W-1:0]     occupancy
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

  // Threshold register
  logic [ufq_pkg::SEV_W-1:0] urgent_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      urgent_threshold <= ufq_pkg::THRESHOLD_RESET;
    end else if (cfg_we) begin
      urgent_threshold <= cfg_data;
    end
  end

  // Handshake: take an item unless a finished result is held up
  logic accept;
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  // Entry count
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             is_empty;
  logic             is_full;
  logic             enq_ok;
  logic             deq_ok;
  logic             urgent;

  assign is_empty = (count == '0);
  assign is_full  = (count >= DEPTH_CNT);
  assign urgent   = (entry_severity >= urgent_threshold);
  assign enq_ok   = accept & (cmd == ufq_pkg::CMD_ENQUEUE) & ~is_full;
  assign deq_ok   = accept & (cmd == ufq_pkg::CMD_DEQUEUE) & ~is_empty;

  always_comb begin
    count_next = count;
    if (enq_ok) begin
      count_next = count + CNT_W'(1);
    end else if (deq_ok) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Row of cells, cell 0 holds the front entry
  ufq_pkg::entry_t new_entry;
  ufq_pkg::entry_t cells [QUEUE_DEPTH];
  ufq_pkg::entry_t zero_entry;

  assign new_entry  = '{id: entry_id, age: entry_age, sev: entry_severity};
  assign zero_entry = '0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    ufq_pkg::cell_ctrl_t ctrl;
    ufq_pkg::entry_t     left_in;
    ufq_pkg::entry_t     right_in;

    // Front cell takes a new urgent entry; the last cell pulls in nothing useful
    if (i == 0) begin : g_front
      assign left_in = new_entry;
    end else begin : g_mid
      assign left_in = cells[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_back
      assign right_in = zero_entry;
    end else begin : g_inner
      assign right_in = cells[i+1];
    end

    always_comb begin
      if (deq_ok) begin
        ctrl.op = ufq_pkg::OP_TAKE_RIGHT;
      end else if (enq_ok && urgent) begin
        ctrl.op = ufq_pkg::OP_TAKE_LEFT;
      end else if (enq_ok && (count == CNT_W'(i))) begin
        ctrl.op = ufq_pkg::OP_LOAD;
      end else begin
        ctrl.op = ufq_pkg::OP_HOLD;
      end
    end

    ufq_cell u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .left  (left_in),
      .right (right_in),
      .load  (new_entry),
      .q     (cells[i])
    );
  end

  // Result of this item, from the row as it stands before the shift
  logic [ufq_pkg::STAT_W-1:0] status_next;
  ufq_pkg::entry_t            popped_next;
  ufq_pkg::entry_t            head_pick;
  ufq_pkg::entry_t            head_next;
  logic [CNT_W+ufq_pkg::OCC_W-1:0] count_ext;

  always_comb begin
    status_next = ufq_pkg::STATUS_DONE;
    if (cmd == ufq_pkg::CMD_ENQUEUE) begin
      if (is_full) begin
        status_next = ufq_pkg::STATUS_FULL;
      end
    end else begin
      if (is_empty) begin
        status_next = ufq_pkg::STATUS_EMPTY;
      end
    end
  end

  assign popped_next = deq_ok ? cells[0] : zero_entry;

  always_comb begin
    if (deq_ok) begin
      head_pick = cells[1];
    end else if (enq_ok && (urgent || is_empty)) begin
      head_pick = new_entry;
    end else begin
      head_pick = cells[0];
    end
  end

  // Drop the head when nothing is left
  assign head_next = (count_next != '0) ? head_pick : zero_entry;
  assign count_ext = {{ufq_pkg::OCC_W{1'b0}}, count_next};

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status          <= status_next;
      popped_id       <= popped_next.id;
      popped_age      <= popped_next.age;
      popped_severity <= popped_next.sev;
      head_valid      <= (count_next != '0);
      head_id         <= head_next.id;
      head_age        <= head_next.age;
      head_severity   <= head_next.sev;
      occupancy       <= count_ext[ufq_pkg::OCC_W-1:0];
    end
  end

endmodule
